// ----- rtl/core/pidaw_pkg.sv -----
// Types, codes and saturation helper shared by the PID controller files.
`default_nettype none

package pidaw_pkg;

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_START  = 2'd1,
    MODE_STOP   = 2'd2
  } pidaw_mode_e;

  typedef enum logic [2:0] {
    REG_KP = 3'd0,
    REG_KI = 3'd1,
    REG_KD = 3'd2,
    REG_LO = 3'd3,
    REG_HI = 3'd4
  } pidaw_reg_e;

  localparam int unsigned QFrac = 16;

  localparam logic signed [31:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMin = -32'sh8000_0000;
  localparam logic signed [65:0] QMaxWide = 66'sd2147483647;
  localparam logic signed [65:0] QMinWide = -66'sd2147483648;

  typedef struct packed {
    logic signed [31:0] kp;
    logic signed [31:0] ki;
    logic signed [31:0] kd;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } pidaw_cfg_t;

  typedef struct packed {
    logic               on;
    logic               first;
    logic signed [31:0] integ;
    logic signed [31:0] last_err;
  } pidaw_state_t;

  typedef struct packed {
    logic signed [31:0] actuation;
    logic signed [31:0] error_value;
    logic               limited;
  } pidaw_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > QMaxWide) begin
      r = QMax;
    end else if (v < QMinWide) begin
      r = QMin;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pid_controller_antiwindup_unit.sv -----
// PID controller with conditional-integration anti-windup, APB setup and valid/ready channels.
// An accepted transaction is held in the input register; a sample's result then moves to
// the result register. Throughput: one transaction per cycle unless a result is held back; the
// combinational update between the two registers also closes the integrator feedback loop.
// Reset: asynchronous, active low; gains clear to zero, limits open to the full range,
// the controller is stopped, the integrator and previous error clear to zero.
`default_nettype none

module pid_controller_antiwindup_unit import pidaw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [4:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic        [1:0]  mode_i,
  input  logic signed [31:0] setpoint_i,
  input  logic signed [31:0] measurement_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] actuation_o,
  output logic signed [31:0] error_value_o,
  output logic               limited_o
);

  pidaw_cfg_t         cfg_q;
  pidaw_state_t       state_q;
  pidaw_state_t       state_d;
  pidaw_res_t         res_d;
  pidaw_res_t         res_q;
  logic               produce;
  logic               s1_valid_q;
  logic        [1:0]  s1_mode_q;
  logic signed [31:0] s1_sp_q;
  logic signed [31:0] s1_ms_q;
  logic               out_valid_q;
  logic               out_free;
  logic               advance;
  logic               cfg_wr;
  logic        [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp <= '0;
      cfg_q.ki <= '0;
      cfg_q.kd <= '0;
      cfg_q.lo <= QMin;
      cfg_q.hi <= QMax;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_KP:  cfg_q.kp <= pwdata;
        REG_KI:  cfg_q.ki <= pwdata;
        REG_KD:  cfg_q.kd <= pwdata;
        REG_LO:  cfg_q.lo <= pwdata;
        REG_HI:  cfg_q.hi <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KP:  prdata = cfg_q.kp;
      REG_KI:  prdata = cfg_q.ki;
      REG_KD:  prdata = cfg_q.kd;
      REG_LO:  prdata = cfg_q.lo;
      REG_HI:  prdata = cfg_q.hi;
      default: prdata = '0;
    endcase
  end

  pidaw_step u_step (
    .mode_i        (s1_mode_q),
    .setpoint_i    (s1_sp_q),
    .measurement_i (s1_ms_q),
    .cfg_i         (cfg_q),
    .state_i       (state_q),
    .state_o       (state_d),
    .res_o         (res_d),
    .produce_o     (produce)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = s1_valid_q && (!produce || out_free);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_mode_q <= mode_i;
      s1_sp_q   <= setpoint_i;
      s1_ms_q   <= measurement_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.on       <= 1'b0;
      state_q.first    <= 1'b1;
      state_q.integ    <= '0;
      state_q.last_err <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && produce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && produce) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign actuation_o   = res_q.actuation;
  assign error_value_o = res_q.error_value;
  assign limited_o     = res_q.limited;

  // The input side stalls only when a result is held back by the consumer.
  a_stall_from_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !in_ready_o) |-> (out_valid_q && !out_ready_i))
    else $error("input stalled without output backpressure");

  // A computed sample always lands in the result register.
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && produce) |=> out_valid_q)
    else $error("computed sample did not reach the result register");

  // A new result only appears after a sample taken while the controller ran.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && state_q.on))
    else $error("result produced without a running sample");

endmodule

`default_nettype wire

// ----- rtl/core/pidaw_step.sv -----
// Combinational PID update with conditional integration for one transaction.
`default_nettype none

module pidaw_step import pidaw_pkg::*; (
  input  logic               [1:0]  mode_i,
  input  logic signed        [31:0] setpoint_i,
  input  logic signed        [31:0] measurement_i,
  input  pidaw_cfg_t                cfg_i,
  input  pidaw_state_t              state_i,
  output pidaw_state_t              state_o,
  output pidaw_res_t                res_o,
  output logic                      produce_o
);

  logic signed [32:0] diff;
  logic signed [31:0] err;
  logic signed [63:0] p_prod;
  logic signed [63:0] i_prod;
  logic signed [32:0] d_diff;
  logic signed [64:0] d_prod;
  logic signed [31:0] pterm;
  logic signed [31:0] dterm;
  logic signed [31:0] itrial;
  logic signed [65:0] i_sum;
  logic signed [33:0] trial;
  logic signed [33:0] hi_w;
  logic signed [33:0] lo_w;
  logic               in_range;
  logic signed [31:0] act;

  always_comb begin
    diff   = 33'(setpoint_i) - 33'(measurement_i);
    err    = sat32(66'(diff));
    p_prod = cfg_i.kp * err;
    i_prod = cfg_i.ki * err;
    d_diff = 33'(err) - 33'(state_i.last_err);
    d_prod = cfg_i.kd * d_diff;
    pterm  = sat32(66'(p_prod >>> QFrac));
    i_sum  = 66'(state_i.integ) + 66'(i_prod >>> QFrac);
    if (state_i.first) begin
      dterm  = '0;
      itrial = state_i.integ;
    end else begin
      dterm  = sat32(66'(d_prod >>> QFrac));
      itrial = sat32(i_sum);
    end
    trial    = 34'(pterm) + 34'(dterm) + 34'(itrial);
    hi_w     = 34'(cfg_i.hi);
    lo_w     = 34'(cfg_i.lo);
    in_range = (trial <= hi_w) && (trial >= lo_w);
    if (in_range) begin
      act = trial[31:0];
    end else if (trial > hi_w) begin
      act = cfg_i.hi;
    end else begin
      act = cfg_i.lo;
    end
  end

  always_comb begin
    state_o         = state_i;
    produce_o       = 1'b0;
    res_o.actuation   = act;
    res_o.error_value = err;
    res_o.limited     = !in_range;
    unique case (mode_i)
      MODE_START: begin
        if (!state_i.on) begin
          state_o.on    = 1'b1;
          state_o.first = 1'b1;
        end
      end
      MODE_STOP: begin
        state_o.on = 1'b0;
      end
      MODE_SAMPLE: begin
        if (state_i.on) begin
          produce_o        = 1'b1;
          state_o.first    = 1'b0;
          state_o.last_err = err;
          if (in_range) begin
            state_o.integ = itrial;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- tb/sv/pid_controller_antiwindup_unit_test.sv -----
// Self-checking testbench for the PID controller with conditional-integration anti-windup.
module pid_controller_antiwindup_unit_test;
  import pidaw_pkg::*;

  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam logic [2:0] REG_SPARE = 3'd5;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_COUNT = 10;
  localparam int PHASE_ITEMS = 108;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic        [4:0]  paddr;
  logic        [31:0] pwdata;
  logic        [31:0] prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_ready_o;
  logic        [1:0]  mode_i;
  logic signed [31:0] setpoint_i;
  logic signed [31:0] measurement_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] actuation_o;
  logic signed [31:0] error_value_o;
  logic               limited_o;

  logic signed [31:0] kp_q = '0;
  logic signed [31:0] ki_q = '0;
  logic signed [31:0] kd_q = '0;
  logic signed [31:0] lo_q = QMin;
  logic signed [31:0] hi_q = QMax;
  logic               run_on = 1'b0;
  logic               first_pending = 1'b1;
  logic signed [31:0] integ_q = '0;
  logic signed [31:0] last_err_q = '0;

  pidaw_res_t pending_outputs[$];

  int  mismatch_count = 0;
  int  outputs_checked = 0;
  int  items_sent = 0;
  int  effective_items = 0;
  int  settings_used = 0;
  int  cycle_count = 0;
  int  hold_request = 0;
  bit  gaps_on = 1'b0;
  bit  stalls_on = 1'b0;

  pid_controller_antiwindup_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .setpoint_i    (setpoint_i),
    .measurement_i (measurement_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .actuation_o   (actuation_o),
    .error_value_o (error_value_o),
    .limited_o     (limited_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic signed [65:0] clamp_q(input logic signed [65:0] v);
    logic signed [65:0] r;
    r = v;
    if (v > QMaxWide) begin
      r = QMaxWide;
    end else if (v < QMinWide) begin
      r = QMinWide;
    end
    return r;
  endfunction

  // Advances the controller state for one transaction and queues the output it owes.
  // Returns 1 when the transaction changed the state or produced an output.
  function automatic bit step_controller(input logic [1:0] m, input logic signed [31:0] sp,
                                         input logic signed [31:0] ms);
    logic signed [65:0] sp_w, ms_w, err, diff, pterm, dterm, itrial, trial;
    logic signed [65:0] kp_w, ki_w, kd_w, lo_w, hi_w, integ_w, prev_w;
    pidaw_res_t res;
    bit acted;
    acted = 1'b0;
    if (m == MODE_START) begin
      acted = !run_on;
      if (!run_on) begin
        run_on = 1'b1;
        first_pending = 1'b1;
      end
    end else if (m == MODE_STOP) begin
      acted = run_on;
      run_on = 1'b0;
    end else if (m == MODE_SAMPLE && run_on) begin
      acted = 1'b1;
      sp_w = sp;
      ms_w = ms;
      kp_w = kp_q;
      ki_w = ki_q;
      kd_w = kd_q;
      lo_w = lo_q;
      hi_w = hi_q;
      integ_w = integ_q;
      prev_w = last_err_q;
      err = clamp_q(sp_w - ms_w);
      pterm = clamp_q((kp_w * err) >>> QFrac);
      if (first_pending) begin
        dterm = '0;
        itrial = integ_w;
      end else begin
        diff = err - prev_w;
        dterm = clamp_q((kd_w * diff) >>> QFrac);
        itrial = clamp_q(integ_w + ((ki_w * err) >>> QFrac));
      end
      trial = pterm + dterm + itrial;
      if (trial <= hi_w && trial >= lo_w) begin
        integ_q = itrial[31:0];
        res.actuation = trial[31:0];
        res.limited = 1'b0;
      end else begin
        res.actuation = (trial > hi_w) ? hi_q : lo_q;
        res.limited = 1'b1;
      end
      res.error_value = err[31:0];
      last_err_q = err[31:0];
      first_pending = 1'b0;
      pending_outputs.push_back(res);
    end
    return acted;
  endfunction

  task automatic send_item(input logic [1:0] m, input logic [31:0] sp, input logic [31:0] ms);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    setpoint_i <= sp;
    measurement_i <= ms;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    if (step_controller(m, sp, ms)) effective_items++;
  endtask

  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_register(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_KP: kp_q = val;
      REG_KI: ki_q = val;
      REG_KD: kd_q = val;
      REG_LO: lo_q = val;
      REG_HI: hi_q = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [31:0] kp, input logic [31:0] ki,
                               input logic [31:0] kd, input logic [31:0] lo,
                               input logic [31:0] hi);
    set_register(REG_KP, kp);
    set_register(REG_KI, ki);
    set_register(REG_KD, kd);
    set_register(REG_LO, lo);
    set_register(REG_HI, hi);
    settings_used++;
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return $urandom();
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_signal();
    case ($urandom_range(0, 11))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom();
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  task automatic load_random_settings();
    logic [31:0] lo, hi;
    case ($urandom_range(0, 9))
      0: begin
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
      end
      1: begin
        lo = $urandom_range(0, 32'h0040_0000);
        hi = -$urandom_range(0, 32'h0040_0000);
      end
      2: begin
        lo = $urandom();
        hi = $urandom();
      end
      default: begin
        lo = -$urandom_range(0, 32'h0040_0000);
        hi = $urandom_range(0, 32'h0040_0000);
      end
    endcase
    load_settings(pick_gain(), pick_gain(), pick_gain(), lo, hi);
  endtask

  task automatic test_reset_behavior();
    send_item(MODE_SAMPLE, 32'h0001_0000, 32'h0000_0000);
    send_item(MODE_STOP, 32'h0000_0000, 32'h0000_0000);
    send_item(MODE_RESERVED, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(MODE_START, 32'h0000_0000, 32'h0000_0000);
    send_item(MODE_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(MODE_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(MODE_SAMPLE, 32'h0000_0000, 32'h0000_0000);
    send_item(MODE_SAMPLE, 32'hFFFF_FFFF, 32'h0000_0001);
    drain_outputs();
  endtask

  task automatic test_gains_and_limits();
    load_settings(32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 32'hFFF0_0000, 32'h0010_0000);
    send_item(MODE_SAMPLE, 32'h0003_0000, 32'h0001_0000);
    send_item(MODE_SAMPLE, 32'h0005_0000, 32'h0001_0000);
    send_item(MODE_START, 32'h0000_0000, 32'h0000_0000);
    send_item(MODE_SAMPLE, 32'h0000_0000, 32'h0004_0000);
    send_item(MODE_STOP, 32'h0000_0000, 32'h0000_0000);
    send_item(MODE_SAMPLE, 32'h0002_0000, 32'h0000_0000);
    send_item(MODE_START, 32'h0000_0000, 32'h0000_0000);
    send_item(MODE_SAMPLE, 32'h0002_0000, 32'h0000_0000);
    send_item(MODE_SAMPLE, 32'h7FFF_0000, 32'h0000_0000);
    drain_outputs();
    // Inverted limits: every trial output lies outside the window.
    load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    set_register(REG_SPARE, $urandom());
    send_item(MODE_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(MODE_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(MODE_SAMPLE, 32'h0000_0000, 32'h0000_0000);
    drain_outputs();
    load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(MODE_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(MODE_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(MODE_SAMPLE, 32'h0000_0001, 32'h0000_0000);
    drain_outputs();
  endtask

  task automatic test_output_backpressure();
    load_settings(32'h0000_8000, 32'h0000_1000, 32'h0000_4000, 32'hFFC0_0000, 32'h0040_0000);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    send_item(MODE_START, 32'h0000_0000, 32'h0000_0000);
    hold_request = 40;
    repeat (30) send_item(MODE_SAMPLE, pick_signal(), pick_signal());
    drain_outputs();
  endtask

  task automatic test_random_operation();
    int base;
    int sel;
    logic [1:0] m;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      drain_outputs();
      load_random_settings();
      gaps_on = (phase != 4 && phase != PHASE_COUNT - 1);
      stalls_on = gaps_on;
      base = effective_items;
      send_item(MODE_START, pick_signal(), pick_signal());
      while (effective_items - base < PHASE_ITEMS) begin
        sel = $urandom_range(0, 99);
        if (!run_on) begin
          m = (sel < 70) ? MODE_START : 2'($urandom_range(0, 3));
        end else if (sel < 90) begin
          m = MODE_SAMPLE;
        end else if (sel < 94) begin
          m = MODE_STOP;
        end else if (sel < 97) begin
          m = MODE_START;
        end else begin
          m = MODE_RESERVED;
        end
        send_item(m, pick_signal(), pick_signal());
      end
    end
  endtask

  initial begin : result_acceptor
    int stall_len;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        out_ready_i <= 1'b0;
        stall_len = hold_request;
        hold_request = 0;
        repeat (stall_len) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : output_check
    pidaw_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outputs.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected output transaction actuation=%0d error=%0d limited=%0b",
                 $time, actuation_o, error_value_o, limited_o);
      end else begin
        want = pending_outputs.pop_front();
        outputs_checked++;
        if (actuation_o !== want.actuation) begin
          mismatch_count++;
          $display("%0t: actuation expected %0d, got %0d", $time, want.actuation,
                   actuation_o);
        end
        if (error_value_o !== want.error_value) begin
          mismatch_count++;
          $display("%0t: error_value expected %0d, got %0d", $time, want.error_value,
                   error_value_o);
        end
        if (limited_o !== want.limited) begin
          mismatch_count++;
          $display("%0t: limited expected %0b, got %0b", $time, want.limited, limited_o);
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: run exceeded %0d cycles with %0d outputs outstanding", $time,
             CYCLE_LIMIT, pending_outputs.size());
    $display("tb: failure");
    $finish;
  end

  initial begin : main_sequence
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    mode_i = MODE_SAMPLE;
    setpoint_i = '0;
    measurement_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_reset_behavior();
    test_gains_and_limits();
    test_output_backpressure();
    test_random_operation();
    drain_outputs();
    $display("tb: %0d input transactions sent, %0d controller outputs checked,", items_sent,
             outputs_checked);
    $display("tb: %0d gain and limit settings, %0d mismatches, %0d cycles", settings_used,
             mismatch_count, cycle_count);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
